FILE: design/sff_pkg.sv
// ============================================================================
// sff_pkg - shared types for the stereo frame FIFO
// Opcodes, controller states, the command bundle and fixed field widths.
// ============================================================================
package sff_pkg;

   // Fixed widths of the stream fields
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned FILL_W   = 10;
   localparam int unsigned CNT_W    = 32;

   // Request beat: tdata = {right, left}, tuser = opcode
   localparam int unsigned REQ_DATA_W = 2 * SAMPLE_W;
   localparam int unsigned OP_W       = 2;

   // Response beat: left, right, fill, dropped, starved, padded to bytes
   localparam int unsigned RSP_USED_W = 2 * SAMPLE_W + FILL_W + 2 * CNT_W;
   localparam int unsigned RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_STARVE = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_LOAD = 1'b1
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic exec;   // beat accepted: update ring state, launch RAM access
      logic load;   // RAM data valid: capture response payload
   } cmd_type;

endpackage : sff_pkg

FILE: design/sff_ram.sv
// ============================================================================
// sff_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module sff_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : sff_ram

FILE: design/sff_ctrl.sv
// ============================================================================
// sff_ctrl - handshake controller
// Two-state sequencer: accept a beat, wait in ST_LOAD for the RAM read,
// then hand the result to the output register.
// ============================================================================
module sff_ctrl
   import sff_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register empty, or emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && out_free) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            cmd.exec   = req_tvalid && out_free;
         end
         ST_LOAD: cmd.load = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // a load always follows an accepted beat
   a_load_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(cmd.exec))
      else $error("load without preceding accept");

   // a new result never lands on one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // no beat is taken while the RAM read is in flight
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !req_tready)
      else $error("ready raised during load");

endmodule : sff_ctrl

FILE: design/sff_datapath.sv
// ============================================================================
// sff_datapath - ring indices, counters and frame store
// Executes one opcode per exec command; captures popped samples on load.
// ============================================================================
module sff_datapath
   import sff_pkg::*;
#(
   parameter int unsigned RING_DEPTH  = 1024,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [OP_W-1:0]       op_bits,
   input  logic [SAMPLE_W-1:0]   left_in,
   input  logic [SAMPLE_W-1:0]   right_in,
   output logic                  ok,
   output logic [SAMPLE_W-1:0]   left_out,
   output logic [SAMPLE_W-1:0]   right_out,
   output logic [FILL_W-1:0]     fill_count,
   output logic [CNT_W-1:0]      dropped_count,
   output logic [CNT_W-1:0]      starved_count
);

   localparam int unsigned IW = $clog2(RING_DEPTH);
   localparam int unsigned FW = IW + 1;
   localparam int unsigned SLOT_W = 2 * SAMPLE_BITS;

   op_type opcode;

   logic [IW-1:0]    wr_idx_ff, wr_idx_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] drop_ff, drop_in;
   logic [CNT_W-1:0] starve_ff, starve_in;
   logic             ok_ff, ok_in;
   logic             pop_ok_ff, pop_ok_in;

   logic [IW-1:0]    wr_next, rd_next;
   logic             full, empty;
   logic             ram_we;
   logic [SLOT_W-1:0] wr_slot, rd_slot;
   logic [FW-1:0]    fill_wide;

   logic             rsp_ok_ff;
   logic [SAMPLE_W-1:0] left_ff, right_ff;

   assign opcode = op_type'(op_bits);

   assign wr_next = (wr_idx_ff == IW'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next = (rd_idx_ff == IW'(RING_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
   assign full    = (wr_next == rd_idx_ff);
   assign empty   = (wr_idx_ff == rd_idx_ff);

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      drop_in   = drop_ff;
      starve_in = starve_ff;
      ok_in     = ok_ff;
      pop_ok_in = pop_ok_ff;
      ram_we    = 1'b0;
      if (cmd.exec) begin
         ok_in     = 1'b1;
         pop_ok_in = 1'b0;
         case (opcode)
            OP_PUSH: begin
               if (full) begin
                  ok_in   = 1'b0;
                  drop_in = drop_ff + 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  wr_idx_in = wr_next;
               end
            end
            OP_POP: begin
               if (empty) begin
                  ok_in = 1'b0;
               end else begin
                  pop_ok_in = 1'b1;
                  rd_idx_in = rd_next;
               end
            end
            OP_CLEAR:  rd_idx_in = wr_idx_ff;
            OP_STARVE: starve_in = starve_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         drop_ff   <= '0;
         starve_ff <= '0;
         ok_ff     <= 1'b0;
         pop_ok_ff <= 1'b0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         drop_ff   <= drop_in;
         starve_ff <= starve_in;
         ok_ff     <= ok_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   // slot layout: right sample high, left sample low
   assign wr_slot = {SAMPLE_BITS'(right_in), SAMPLE_BITS'(left_in)};

   sff_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (RING_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (wr_slot),
      .rd_en   (cmd.exec),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_slot)
   );

   // response payload, captured once the read data is out of the RAM
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ok_ff <= ok_ff;
         if (pop_ok_ff) begin
            left_ff  <= SAMPLE_W'(rd_slot[SAMPLE_BITS-1:0]);
            right_ff <= SAMPLE_W'(rd_slot[SLOT_W-1:SAMPLE_BITS]);
         end else begin
            left_ff  <= '0;
            right_ff <= '0;
         end
      end
   end

   assign fill_wide = (wr_idx_ff >= rd_idx_ff)
                    ? {1'b0, wr_idx_ff} - {1'b0, rd_idx_ff}
                    : {1'b0, wr_idx_ff} + FW'(RING_DEPTH) - {1'b0, rd_idx_ff};

   assign ok            = rsp_ok_ff;
   assign left_out      = left_ff;
   assign right_out     = right_ff;
   assign fill_count    = FILL_W'(fill_wide);
   assign dropped_count = drop_ff;
   assign starved_count = starve_ff;

   // ring never holds more than depth minus one frames
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_wide <= FW'(RING_DEPTH - 1))
      else $error("fill exceeds ring capacity");

   // a write is only issued for a push that found room
   a_write_on_push: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (wr_idx_ff == $past(wr_next)) && ok_ff)
      else $error("write index did not advance after store");

endmodule : sff_datapath

FILE: design/stereo_frame_fifo_core.sv
// ============================================================================
// stereo_frame_fifo_core - ring FIFO of stereo audio frames
// Push, pop, clear and starvation-record operations on a one-slot-empty ring.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+-----------
//  req_    | in  | left_in[15:0], right_in[31:16]               | opcode[1:0]
//  rsp_    | out | left_out[15:0], right_out[31:16],            | ok[0]
//          |     | fill_count[41:32], dropped_count[73:42],     |
//          |     | starved_count[105:74], zero pad[111:106]     |
//
//  Every accepted beat yields exactly one response beat.
//  Each beat is accepted, then read from the frame store through its
//  registered port; no new beat is taken until the response is loaded.
//  The response sits in an output register; the next request beat is taken
//  in the same cycle as that register is drained (or when it is empty).
//  Synchronous reset empties the ring and clears both counters; no
//  clearing pass, frame store contents are don't-care until pushed.
//  A stalled rsp_ side holds req_tready low until the response is taken.
//
module stereo_frame_fifo_core
   import sff_pkg::*;
#(
   parameter int unsigned RING_DEPTH  = 1024,   // 2 .. 1024, holds depth-1 frames
   parameter int unsigned SAMPLE_BITS = 16      // stored bits per sample, 8 .. 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // left_in, right_in
   input  logic [OP_W-1:0]       req_tuser,   // opcode

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // left_out, right_out, fill_count,
                                              // dropped_count, starved_count, pad
   output logic [0:0]            rsp_tuser    // ok
);

   cmd_type             cmd;
   logic                ok;
   logic [SAMPLE_W-1:0] left_out, right_out;
   logic [FILL_W-1:0]   fill_count;
   logic [CNT_W-1:0]    dropped_count, starved_count;

   // sequencer: accept, then load the result in the following cycle
   sff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // ring state, counters and frame store
   sff_datapath #(
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .op_bits       (req_tuser),
      .left_in       (req_tdata[SAMPLE_W-1:0]),
      .right_in      (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .ok            (ok),
      .left_out      (left_out),
      .right_out     (right_out),
      .fill_count    (fill_count),
      .dropped_count (dropped_count),
      .starved_count (starved_count)
   );

   // Fill and counters come straight from the ring state: it only moves on
   // an accept, and an accept happens only once the pending beat is gone.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, starved_count, dropped_count,
                       fill_count, right_out, left_out};
   assign rsp_tuser = ok;

endmodule : stereo_frame_fifo_core

FILE: test/tb_stereo_frame_fifo_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_stereo_frame_fifo_core - self-checking bench for the stereo frame FIFO
// Streams push/pop/clear/starve beats into the core, runs a scoreboard ring
// alongside it and compares every response beat field by field.
// ============================================================================
module tb_stereo_frame_fifo_core;
   import sff_pkg::*;

   localparam int unsigned DEPTH       = 1024;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned MAX_REPORTS = 10;

   // one request beat as the stimulus sees it
   typedef struct {
      op_type              op;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } frame_cmd_type;

   // what one response beat should carry
   typedef struct packed {
      logic                ok;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic [FILL_W-1:0]   fill;
      logic [CNT_W-1:0]    dropped;
      logic [CNT_W-1:0]    starved;
   } ring_status_type;

   // rsp_tdata layout, top bit down
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [CNT_W-1:0]     starved;
      logic [CNT_W-1:0]     dropped;
      logic [FILL_W-1:0]    fill;
      logic [SAMPLE_W-1:0]  right;
      logic [SAMPLE_W-1:0]  left;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // left_in, right_in
   logic [OP_W-1:0]       req_tuser = '0;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // left, right, fill, dropped, starved, pad
   logic [0:0]            rsp_tuser;        // ok

   stereo_frame_fifo_core #(
      .RING_DEPTH  (DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------------
   // Scoreboard ring: mirrors head, tail and both counters of the core
   // ------------------------------------------------------------------------
   logic [2*SAMPLE_W-1:0] sb_frames [DEPTH];
   int unsigned           sb_head    = 0;
   int unsigned           sb_tail    = 0;
   logic [CNT_W-1:0]      sb_drops   = '0;
   logic [CNT_W-1:0]      sb_starves = '0;

   frame_cmd_type   frame_requests [$];   // beats not yet offered
   ring_status_type expected_status [$];  // predictions for accepted beats
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     hold_rsp_cycles = 0;  // long receiver stall, set by stimulus
   int unsigned     req_beats = 0;
   int unsigned     rsp_beats = 0;
   bit              req_taken = 1'b0;
   bit              rsp_taken = 1'b0;

   // Apply one operation to the scoreboard ring and return the status it gives
   function automatic ring_status_type next_ring_status(op_type op,
                                                        logic [SAMPLE_W-1:0] left,
                                                        logic [SAMPLE_W-1:0] right);
      ring_status_type st;
      int unsigned     nxt;
      st = '0;
      case (op)
         OP_PUSH: begin
            nxt = (sb_head + 1 == DEPTH) ? 0 : sb_head + 1;
            if (nxt != sb_tail) begin
               sb_frames[sb_head] = {right, left};
               sb_head = nxt;
               st.ok = 1'b1;
            end else begin
               sb_drops = sb_drops + 1'b1;   // full: frame dropped
            end
         end
         OP_POP: begin
            if (sb_tail != sb_head) begin
               {st.right, st.left} = sb_frames[sb_tail];
               sb_tail = (sb_tail + 1 == DEPTH) ? 0 : sb_tail + 1;
               st.ok = 1'b1;
            end
         end
         OP_CLEAR: begin
            sb_tail = sb_head;               // contents stay, just unreadable
            st.ok = 1'b1;
         end
         default: begin
            sb_starves = sb_starves + 1'b1;
            st.ok = 1'b1;
         end
      endcase
      st.fill    = FILL_W'((sb_head >= sb_tail) ? sb_head - sb_tail
                                                : sb_head + DEPTH - sb_tail);
      st.dropped = sb_drops;
      st.starved = sb_starves;
      return st;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, reset and cycle limit
   // ------------------------------------------------------------------------
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: changes inputs on the falling edge only
   // ------------------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(negedge clock) begin
      logic          nxt_valid;
      frame_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_taken) begin
            nxt_valid = 1'b0;
            req_taken = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (frame_requests.size() > 0) begin
               c = frame_requests.pop_front();
               req_tdata <= {c.right, c.left};
               req_tuser <= c.op;
               nxt_valid = 1'b1;
               // every other run of 64 beats goes back to back
               send_gap = req_beats[6] ? 0 : $urandom_range(0, 3);
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // ------------------------------------------------------------------------
   // Response ready: per-beat random stall, plus an occasional long hold
   // ------------------------------------------------------------------------
   int unsigned recv_gap = 0;

   always @(negedge clock) begin
      logic nxt_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            recv_gap = rsp_beats[5] ? 0 : $urandom_range(0, 3);
         end
         if (hold_rsp_cycles > 0) begin
            hold_rsp_cycles--;
            nxt_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
         rsp_tready <= nxt_ready;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predicts on request accept, checks on response accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      ring_status_type want;
      rsp_word_type    got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(next_ring_status(op_type'(req_tuser),
                                                       req_tdata[SAMPLE_W-1:0],
                                                       req_tdata[2*SAMPLE_W-1:SAMPLE_W]));
            req_beats++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            rsp_beats++;
            rsp_taken = 1'b1;
            if (expected_status.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("[%0t] response beat with nothing outstanding: ok=%0b fill=%0d",
                           $realtime, rsp_tuser[0], got.fill);
            end else begin
               want = expected_status.pop_front();
               if (rsp_tuser[0] !== want.ok || got.left !== want.left ||
                   got.right !== want.right || got.fill !== want.fill ||
                   got.dropped !== want.dropped || got.starved !== want.starved ||
                   got.pad !== '0) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("[%0t] beat %0d mismatch: exp ok=%0b l=%h r=%h fill=%0d drop=%0d starve=%0d",
                              $realtime, rsp_beats, want.ok, want.left, want.right,
                              want.fill, want.dropped, want.starved);
                     $display("    got ok=%0b l=%h r=%h fill=%0d drop=%0d starve=%0d pad=%h",
                              rsp_tuser[0], got.left, got.right, got.fill, got.dropped,
                              got.starved, got.pad);
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_cmd(op_type op, logic [SAMPLE_W-1:0] left,
                            logic [SAMPLE_W-1:0] right);
      frame_cmd_type c;
      c.op    = op;
      c.left  = left;
      c.right = right;
      frame_requests.push_back(c);
   endtask

   // sender holds off until every outstanding response is back
   task automatic wait_drained();
      while (frame_requests.size() > 0 || req_tvalid || expected_status.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned push_w;
      int unsigned pick;
      op_type      op;

      // directed: edges of the sample range, every opcode, empty/clear cases
      queue_cmd(OP_POP,    16'h1234, 16'h5678);   // pop on empty ring
      queue_cmd(OP_PUSH,   16'h7fff, 16'h8000);
      queue_cmd(OP_PUSH,   16'h8000, 16'h7fff);
      queue_cmd(OP_PUSH,   16'h0000, 16'hffff);
      queue_cmd(OP_PUSH,   16'hffff, 16'h0000);
      queue_cmd(OP_POP,    16'hffff, 16'hffff);
      queue_cmd(OP_POP,    16'h0000, 16'h0000);
      queue_cmd(OP_STARVE, 16'hffff, 16'hffff);
      queue_cmd(OP_CLEAR,  16'h0000, 16'h0000);   // clear with frames held
      queue_cmd(OP_POP,    16'h0000, 16'h0000);   // nothing readable after clear
      queue_cmd(OP_PUSH,   16'h5555, 16'haaaa);
      queue_cmd(OP_PUSH,   16'haaaa, 16'h5555);
      queue_cmd(OP_POP,    16'h0000, 16'h0000);
      queue_cmd(OP_POP,    16'h0000, 16'h0000);
      queue_cmd(OP_POP,    16'h0000, 16'h0000);
      queue_cmd(OP_CLEAR,  16'hffff, 16'hffff);   // clear on empty ring
      queue_cmd(OP_STARVE, 16'h0000, 16'h0000);
      wait_drained();

      // fill past full so pushes drop; receiver stalls hard at the start
      @(posedge clock);
      hold_rsp_cycles = 400;
      for (int i = 0; i < DEPTH + 6; i++)
         queue_cmd(OP_PUSH, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      wait_drained();

      // random mix in segments with varying push bias, so the fill level wanders
      for (int seg = 0; seg < 18; seg++) begin
         pick = $urandom_range(0, 2);
         push_w = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
         for (int i = 0; i < 50; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               op = OP_CLEAR;
            else if (pick < 13)
               op = OP_STARVE;
            else if ($urandom_range(0, 99) < push_w)
               op = OP_PUSH;
            else
               op = OP_POP;
            queue_cmd(op, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
         end
         if (seg == 9)
            wait_drained();
      end
      wait_drained();
      repeat (20) @(posedge clock);

      if (error_count == 0 && expected_status.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
